// ===== sv/qvmm_pkg.sv =====
// shared types and constants of the q15 vector-matrix multiply-accumulate
package qvmm_pkg;

	localparam int COEF_BITS    = 16;
	localparam int Q15_SHIFT    = 15;
	localparam int CFG_BITS     = 11;
	localparam int CFG_IDX_BITS = 2;

	// configuration register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_ROWS     = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_NUM_COLS     = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_COMPLEX_MODE = 2'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_OPEN = 2'b01,
		ST_BUSY = 2'b10
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load_we;
		logic rd_en;
		logic mul_en;
		logic acc_en;
		logic acc_close;
		logic cmode;
	} cmd_t;

endpackage

// ===== sv/qvmm_ctrl.sv =====
// controller: handshakes, configuration, positions and pipeline control
module qvmm_ctrl #(
	parameter int MAX_ROWS = 1024,
	parameter int MAX_COLS = 1024,
	localparam int POS_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [qvmm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [qvmm_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               action,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [COL_W-1:0]                   column_index,
	output logic                               last_column,
	output qvmm_pkg::cmd_t                     cmd,
	output logic [POS_W-1:0]                   wr_addr,
	output logic [POS_W-1:0]                   rd_addr
);

	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int CCNT_W = $clog2(MAX_COLS + 1);

	qvmm_pkg::state_t state_q;
	logic [qvmm_pkg::CFG_BITS-1:0] num_rows_q;
	logic [qvmm_pkg::CFG_BITS-1:0] num_cols_q;
	logic                          complex_q;
	logic [POS_W-1:0]              load_pos_q;
	logic [POS_W-1:0]              row_pos_q;
	logic [COL_W-1:0]              col_pos_q;
	logic                          mac_s1, close_s1, mac_s2, close_s2;
	logic                          out_valid_q;
	logic [COL_W-1:0]              col_idx_q;
	logic                          last_q;

	logic [RCNT_W-1:0] rows_lim;
	logic [CCNT_W-1:0] cols_lim;
	logic [RCNT_W:0]   load_next, row_next;
	logic [CCNT_W:0]   col_next;
	logic              load_wrap, closes, col_wrap;
	logic              in_fire, ld_fire, mac_fire, close_fire, out_fire;

	// zero acts as one, large values saturate
	always_comb begin
		if (num_rows_q == '0) begin
			rows_lim = RCNT_W'(1);
		end else if (32'(num_rows_q) > 32'(MAX_ROWS)) begin
			rows_lim = RCNT_W'(MAX_ROWS);
		end else begin
			rows_lim = RCNT_W'(num_rows_q);
		end
		if (num_cols_q == '0) begin
			cols_lim = CCNT_W'(1);
		end else if (32'(num_cols_q) > 32'(MAX_COLS)) begin
			cols_lim = CCNT_W'(MAX_COLS);
		end else begin
			cols_lim = CCNT_W'(num_cols_q);
		end
	end

	assign load_next = (RCNT_W + 1)'(load_pos_q) + 1'b1;
	assign row_next  = (RCNT_W + 1)'(row_pos_q) + 1'b1;
	assign col_next  = (CCNT_W + 1)'(col_pos_q) + 1'b1;
	assign load_wrap = load_next >= {1'b0, rows_lim};
	assign closes    = row_next >= {1'b0, rows_lim};
	assign col_wrap  = col_next >= {1'b0, cols_lim};

	// a column-closing coefficient waits until the previous result is gone
	assign in_ready   = !(action && closes && (state_q != qvmm_pkg::ST_OPEN));
	assign in_fire    = in_valid && in_ready;
	assign ld_fire    = in_fire && !action;
	assign mac_fire   = in_fire && action;
	assign close_fire = mac_fire && closes;
	assign out_fire   = out_valid_q && out_ready;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= qvmm_pkg::CFG_BITS'(1024);
			num_cols_q <= qvmm_pkg::CFG_BITS'(1024);
			complex_q  <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				qvmm_pkg::REG_NUM_ROWS:     num_rows_q <= cfg_data;
				qvmm_pkg::REG_NUM_COLS:     num_cols_q <= cfg_data;
				qvmm_pkg::REG_COMPLEX_MODE: complex_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= qvmm_pkg::ST_OPEN;
			load_pos_q  <= '0;
			row_pos_q   <= '0;
			col_pos_q   <= '0;
			mac_s1      <= 1'b0;
			close_s1    <= 1'b0;
			mac_s2      <= 1'b0;
			close_s2    <= 1'b0;
			out_valid_q <= 1'b0;
			col_idx_q   <= '0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				qvmm_pkg::ST_OPEN: begin
					if (close_fire) begin
						state_q <= qvmm_pkg::ST_BUSY;
					end
				end
				qvmm_pkg::ST_BUSY: begin
					if (out_fire) begin
						state_q <= qvmm_pkg::ST_OPEN;
					end
				end
				default: state_q <= qvmm_pkg::ST_OPEN;
			endcase

			if (ld_fire) begin
				load_pos_q <= load_wrap ? '0 : POS_W'(load_next);
			end
			if (mac_fire) begin
				row_pos_q <= closes ? '0 : POS_W'(row_next);
			end
			if (close_fire) begin
				col_pos_q <= col_wrap ? '0 : COL_W'(col_next);
				col_idx_q <= col_pos_q;
				last_q    <= col_wrap;
			end

			mac_s1   <= mac_fire;
			close_s1 <= close_fire;
			mac_s2   <= mac_s1;
			close_s2 <= close_s1;

			if (close_s2) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd.load_we   = ld_fire;
		cmd.rd_en     = mac_fire;
		cmd.mul_en    = mac_s1;
		cmd.acc_en    = mac_s2;
		cmd.acc_close = close_s2;
		cmd.cmode     = complex_q;
	end

	assign wr_addr      = load_pos_q;
	assign rd_addr      = row_pos_q;
	assign out_valid    = out_valid_q;
	assign column_index = col_idx_q;
	assign last_column  = last_q;

	// at most one column result between the closing beat and delivery
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({close_s1, close_s2, out_valid_q}))
		else $error("more than one column result outstanding");

	a_open_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == qvmm_pkg::ST_OPEN) |-> !(close_s1 || close_s2 || out_valid_q))
		else $error("open state with a result outstanding");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		close_s2 |-> !out_valid_q)
		else $error("result lands on an occupied output register");

	a_reopen: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |=> (state_q == qvmm_pkg::ST_OPEN))
		else $error("controller did not reopen after result delivery");

endmodule

// ===== sv/qvmm_dp.sv =====
// datapath: vector store, multipliers, accumulators and result register
module qvmm_dp #(
	parameter int MAX_ROWS    = 1024,
	parameter int SAMPLE_BITS = 24,
	localparam int POS_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int PROD_W     = SAMPLE_BITS + qvmm_pkg::COEF_BITS,
	localparam int ACC_W      = PROD_W + $clog2(MAX_ROWS),
	localparam int Y_W        = ACC_W - qvmm_pkg::Q15_SHIFT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  qvmm_pkg::cmd_t                        cmd,
	input  logic [POS_W-1:0]                      wr_addr,
	input  logic [POS_W-1:0]                      rd_addr,
	input  logic signed [SAMPLE_BITS-1:0]         x_real,
	input  logic signed [SAMPLE_BITS-1:0]         x_imag,
	input  logic signed [qvmm_pkg::COEF_BITS-1:0] coef,
	output logic signed [Y_W-1:0]                 y_real,
	output logic signed [Y_W-1:0]                 y_imag
);

	logic [2*SAMPLE_BITS-1:0]              vec_mem_q [MAX_ROWS];
	logic [2*SAMPLE_BITS-1:0]              rd_s1;
	logic signed [qvmm_pkg::COEF_BITS-1:0] coef_s1;
	logic signed [PROD_W-1:0]              prod_r_s2, prod_i_s2;
	logic signed [ACC_W-1:0]               acc_r_q, acc_i_q;
	logic signed [ACC_W-1:0]               sum_r, sum_i;
	logic signed [Y_W-1:0]                 y_r_q, y_i_q;

	// imaginary part in the upper half
	always_ff @(posedge clk) begin
		if (cmd.load_we) begin
			vec_mem_q[wr_addr] <= {x_imag, x_real};
		end
		if (cmd.rd_en) begin
			rd_s1   <= vec_mem_q[rd_addr];
			coef_s1 <= coef;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_r_s2 <= $signed(rd_s1[SAMPLE_BITS-1:0]) * coef_s1;
			prod_i_s2 <= $signed(rd_s1[2*SAMPLE_BITS-1:SAMPLE_BITS]) * coef_s1;
		end
	end

	assign sum_r = acc_r_q + ACC_W'(prod_r_s2);
	assign sum_i = acc_i_q + ACC_W'(prod_i_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_r_q <= '0;
			acc_i_q <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.acc_close) begin
				acc_r_q <= '0;
				acc_i_q <= '0;
			end else begin
				acc_r_q <= sum_r;
				if (cmd.cmode) begin
					acc_i_q <= sum_i;
				end
			end
		end
	end

	// dropping the low bits of a two's complement sum is a floor shift
	always_ff @(posedge clk) begin
		if (cmd.acc_en && cmd.acc_close) begin
			y_r_q <= sum_r[ACC_W-1:qvmm_pkg::Q15_SHIFT];
			y_i_q <= cmd.cmode ? sum_i[ACC_W-1:qvmm_pkg::Q15_SHIFT] : '0;
		end
	end

	assign y_real = y_r_q;
	assign y_imag = y_i_q;

endmodule

// ===== sv/q15_vector_matrix_mac.sv =====
// top level of the q15 vector-matrix multiply-accumulate
// Computes y = A' x column by column. A beat with action low writes the next vector
// element (both parts) into the on-chip store; a beat with action high carries the
// next Q15 coefficient in column-major order, which is multiplied with the stored
// element of the current row and accumulated. After num_rows coefficients the column
// sum, floor-shifted right by 15, leaves on the output channel with its column index
// and a last-column flag; y_imag is zero unless complex_mode is set. Input beats are
// taken one per cycle, loads and coefficients mixed freely. The column sum passes the
// store read, multiply and accumulate stages on its way to the output channel, and a
// column-closing coefficient is held off while the previous column result is still in
// flight or waiting in the output register. Configuration writes are taken at any
// time but belong between passes; register values of zero act as one and values
// beyond MAX_ROWS or MAX_COLS saturate. The store is not cleared after reset: read
// an entry only after it was loaded.
module q15_vector_matrix_mac #(
	parameter int MAX_ROWS    = 1024,
	parameter int MAX_COLS    = 1024,
	parameter int SAMPLE_BITS = 24,
	localparam int POS_W      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
	localparam int COL_W      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
	localparam int Y_W        = SAMPLE_BITS + qvmm_pkg::COEF_BITS + $clog2(MAX_ROWS)
	                            - qvmm_pkg::Q15_SHIFT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [qvmm_pkg::CFG_IDX_BITS-1:0]     cfg_index,
	input  logic [qvmm_pkg::CFG_BITS-1:0]         cfg_data,
	// input item channel
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic signed [SAMPLE_BITS-1:0]         x_real,
	input  logic signed [SAMPLE_BITS-1:0]         x_imag,
	input  logic signed [qvmm_pkg::COEF_BITS-1:0] coef,
	// result channel
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [Y_W-1:0]                 y_real,
	output logic signed [Y_W-1:0]                 y_imag,
	output logic [COL_W-1:0]                      column_index,
	output logic                                  last_column
);

	qvmm_pkg::cmd_t   cmd;
	logic [POS_W-1:0] wr_addr;
	logic [POS_W-1:0] rd_addr;

	// controller owns handshakes, register file, row/column/load positions
	qvmm_ctrl #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.column_index (column_index),
		.last_column  (last_column),
		.cmd          (cmd),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr)
	);

	// datapath holds the store, the two 24x16 multipliers and the accumulators
	qvmm_dp #(
		.MAX_ROWS    (MAX_ROWS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.x_real  (x_real),
		.x_imag  (x_imag),
		.coef    (coef),
		.y_real  (y_real),
		.y_imag  (y_imag)
	);

endmodule
